### rtl/core/fpsa_pkg.sv
// ----------------------------------------------------------------------------
// fpsa_pkg
// Shared types and constants for the free page stack allocator.
// ----------------------------------------------------------------------------
package fpsa_pkg;

  localparam int unsigned MaxPages  = 32768;
  localparam int unsigned PageShift = 12;
  localparam int unsigned AddrW     = 32;
  localparam int unsigned PageNumW  = AddrW - PageShift;
  localparam int unsigned CntW      = PageNumW + 1;
  localparam int unsigned DepthW    = $clog2(MaxPages + 1);
  localparam int unsigned IdxW      = (MaxPages > 1) ? $clog2(MaxPages) : 1;
  localparam int unsigned FreeCntW  = 16;
  localparam int unsigned CfgIdxW   = 1;

  localparam logic [AddrW-1:0] KernelEndReset = 32'h8000_0000;
  localparam logic [AddrW-1:0] MemoryTopReset = 32'h8800_0000;

  localparam logic [CfgIdxW-1:0] CfgKernelEnd = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgMemoryTop = 1'b1;

  typedef enum logic [1:0] {
    ActAlloc = 2'd0,
    ActFree  = 2'd1,
    ActInit  = 2'd2,
    ActNone  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StatOk      = 2'd0,
    StatEmpty   = 2'd1,
    StatBadAddr = 2'd2,
    StatFull    = 2'd3
  } status_e;

  typedef enum logic {
    StIdle = 1'b0,
    StRead = 1'b1
  } state_e;

  typedef struct packed {
    logic [1:0]       action;
    logic [AddrW-1:0] page_addr_in;
  } in_word_t;

  typedef struct packed {
    logic [AddrW-1:0]    page_addr_out;
    logic [1:0]          status;
    logic [FreeCntW-1:0] free_count;
  } out_word_t;

  typedef struct packed {
    logic                we;
    logic                re;
    logic [IdxW-1:0]     addr;
    logic [PageNumW-1:0] wdata;
  } ram_req_t;

endpackage

### rtl/core/fpsa_stack_ram.sv
// ----------------------------------------------------------------------------
// fpsa_stack_ram
// Single-port page stack memory with registered read.
// ----------------------------------------------------------------------------
module fpsa_stack_ram (
  input  logic                              clk_i,
  input  fpsa_pkg::ram_req_t                req_i,
  output logic [fpsa_pkg::PageNumW-1:0]     rdata_o
);

  logic [fpsa_pkg::PageNumW-1:0] mem [fpsa_pkg::MaxPages];
  logic [fpsa_pkg::PageNumW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.addr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/fpsa_ctrl.sv
// ----------------------------------------------------------------------------
// fpsa_ctrl
// Stack pointer, init region tracking, sequencing and output register.
// ----------------------------------------------------------------------------
module fpsa_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fpsa_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fpsa_pkg::out_word_t               out_word_o,
  input  logic [fpsa_pkg::AddrW-1:0]        kernel_end_i,
  input  logic [fpsa_pkg::AddrW-1:0]        memory_top_i,
  output fpsa_pkg::ram_req_t                ram_req_o,
  input  logic [fpsa_pkg::PageNumW-1:0]     ram_rdata_i
);

  fpsa_pkg::state_e                state_q, state_d;
  logic [fpsa_pkg::DepthW-1:0]     depth_q, depth_d;
  logic [fpsa_pkg::DepthW-1:0]     mark_q, mark_d;
  logic [fpsa_pkg::PageNumW-1:0]   base_q, base_d;
  logic                            from_init_q, from_init_d;
  logic [fpsa_pkg::PageNumW-1:0]   init_val_q, init_val_d;
  logic                            out_valid_q, out_valid_d;
  fpsa_pkg::out_word_t             out_word_q, out_word_d;

  logic                            accept;
  logic [fpsa_pkg::DepthW-1:0]     pop_idx;
  logic                            bad_addr;
  logic [fpsa_pkg::CntW-1:0]       first_page;
  logic [fpsa_pkg::CntW-1:0]       top_page;
  logic [fpsa_pkg::CntW-1:0]       region_cnt;
  logic                            init_full;
  logic [fpsa_pkg::DepthW-1:0]     init_depth;
  logic [fpsa_pkg::PageNumW-1:0]   rd_page;

  assign in_stall_o = (state_q == fpsa_pkg::StRead) || (out_valid_q && out_stall_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign pop_idx    = depth_q - fpsa_pkg::DepthW'(1);

  assign bad_addr = (in_word_i.page_addr_in[fpsa_pkg::PageShift-1:0] != '0) ||
                    (in_word_i.page_addr_in < kernel_end_i) ||
                    (in_word_i.page_addr_in >= memory_top_i);

  // init region as a page range, rounded up start
  assign first_page = fpsa_pkg::CntW'(({1'b0, kernel_end_i} +
                        (fpsa_pkg::AddrW + 1)'((1 << fpsa_pkg::PageShift) - 1))
                        >> fpsa_pkg::PageShift);
  assign top_page   = {1'b0, memory_top_i[fpsa_pkg::AddrW-1:fpsa_pkg::PageShift]};
  assign region_cnt = (first_page < top_page) ? (top_page - first_page) : '0;
  assign init_full  = region_cnt > fpsa_pkg::CntW'(fpsa_pkg::MaxPages);
  assign init_depth = init_full ? fpsa_pkg::DepthW'(fpsa_pkg::MaxPages)
                                : fpsa_pkg::DepthW'(region_cnt);

  assign rd_page = from_init_q ? init_val_q : ram_rdata_i;

  always_comb begin
    state_d     = state_q;
    depth_d     = depth_q;
    mark_d      = mark_q;
    base_d      = base_q;
    from_init_d = from_init_q;
    init_val_d  = init_val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_word_d  = out_word_q;
    ram_req_o   = '0;

    unique case (state_q)
      fpsa_pkg::StIdle: begin
        if (accept) begin
          out_valid_d              = 1'b1;
          out_word_d.page_addr_out = '0;
          out_word_d.status        = fpsa_pkg::StatOk;
          out_word_d.free_count    = fpsa_pkg::FreeCntW'(depth_q);
          unique case (fpsa_pkg::action_e'(in_word_i.action))
            fpsa_pkg::ActAlloc: begin
              if (depth_q == '0) begin
                out_word_d.status = fpsa_pkg::StatEmpty;
              end else begin
                out_valid_d    = 1'b0;
                depth_d        = pop_idx;
                from_init_d    = pop_idx < mark_q;
                init_val_d     = base_q + fpsa_pkg::PageNumW'(pop_idx);
                if (pop_idx < mark_q) begin
                  mark_d = pop_idx;
                end
                ram_req_o.re   = 1'b1;
                ram_req_o.addr = pop_idx[fpsa_pkg::IdxW-1:0];
                state_d        = fpsa_pkg::StRead;
              end
            end
            fpsa_pkg::ActFree: begin
              if (bad_addr) begin
                out_word_d.status = fpsa_pkg::StatBadAddr;
              end else if (depth_q >= fpsa_pkg::DepthW'(fpsa_pkg::MaxPages)) begin
                out_word_d.status = fpsa_pkg::StatFull;
              end else begin
                ram_req_o.we          = 1'b1;
                ram_req_o.addr        = depth_q[fpsa_pkg::IdxW-1:0];
                ram_req_o.wdata       =
                  in_word_i.page_addr_in[fpsa_pkg::AddrW-1:fpsa_pkg::PageShift];
                depth_d               = depth_q + fpsa_pkg::DepthW'(1);
                out_word_d.free_count = fpsa_pkg::FreeCntW'(depth_q + fpsa_pkg::DepthW'(1));
              end
            end
            fpsa_pkg::ActInit: begin
              depth_d               = init_depth;
              mark_d                = init_depth;
              base_d                = first_page[fpsa_pkg::PageNumW-1:0];
              out_word_d.status     = init_full ? fpsa_pkg::StatFull : fpsa_pkg::StatOk;
              out_word_d.free_count = fpsa_pkg::FreeCntW'(init_depth);
            end
            fpsa_pkg::ActNone: begin
            end
            default: begin
            end
          endcase
        end
      end
      fpsa_pkg::StRead: begin
        out_valid_d              = 1'b1;
        out_word_d.page_addr_out = {rd_page, {fpsa_pkg::PageShift{1'b0}}};
        out_word_d.status        = fpsa_pkg::StatOk;
        out_word_d.free_count    = fpsa_pkg::FreeCntW'(depth_q);
        state_d                  = fpsa_pkg::StIdle;
      end
      default: begin
        state_d = fpsa_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fpsa_pkg::StIdle;
      depth_q     <= '0;
      mark_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      depth_q     <= depth_d;
      mark_q      <= mark_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    from_init_q <= from_init_d;
    init_val_q  <= init_val_d;
    out_word_q  <= out_word_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

### rtl/core/free_page_stack_allocator_top.sv
// ----------------------------------------------------------------------------
// free_page_stack_allocator_top
// LIFO pool of free 4 KiB pages with alloc, free and init actions.
// ----------------------------------------------------------------------------
// Alloc reads the single-port stack RAM (registered output) and stalls
// the input until the read is done; free, init and the unused action
// need no RAM read. Init does not write the RAM: it records the page
// range as a base page and a low-water mark, and entries below the mark
// read as base plus index, so init time is independent of range size.
// No clearing pass runs after reset. A finished result sits in an
// output register; a new word is taken while that register drains.
module free_page_stack_allocator_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  fpsa_pkg::in_word_t                in_word_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output fpsa_pkg::out_word_t               out_word_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [fpsa_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [fpsa_pkg::AddrW-1:0]        cfg_wdata_i
);

  logic [fpsa_pkg::AddrW-1:0]    kernel_end_q;
  logic [fpsa_pkg::AddrW-1:0]    memory_top_q;
  fpsa_pkg::ram_req_t            ram_req;
  logic [fpsa_pkg::PageNumW-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kernel_end_q <= fpsa_pkg::KernelEndReset;
      memory_top_q <= fpsa_pkg::MemoryTopReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        fpsa_pkg::CfgKernelEnd: kernel_end_q <= cfg_wdata_i;
        fpsa_pkg::CfgMemoryTop: memory_top_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  fpsa_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_word_i    (in_word_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o),
    .kernel_end_i (kernel_end_q),
    .memory_top_i (memory_top_q),
    .ram_req_o    (ram_req),
    .ram_rdata_i  (ram_rdata)
  );

  fpsa_stack_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.free_count <= fpsa_pkg::FreeCntW'(fpsa_pkg::MaxPages)))
    else $error("free_count above pool capacity");

  a_empty_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == fpsa_pkg::StatEmpty)) |->
    ((out_word_o.page_addr_out == '0) && (out_word_o.free_count == '0)))
    else $error("empty status with nonzero address or count");

  a_bad_addr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == fpsa_pkg::StatBadAddr)) |->
    (out_word_o.page_addr_out == '0))
    else $error("rejected free returned an address");

  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_word_i.action == fpsa_pkg::ActAlloc)) |=>
    (in_stall_o || (out_word_o.status == fpsa_pkg::StatEmpty)))
    else $error("word accepted during stack read");
`endif

endmodule

### tb/tb_free_page_stack_allocator_top.sv
// ----------------------------------------------------------------------------
// tb_free_page_stack_allocator_top
// Self-checking bench for the free page stack allocator. A scoreboard keeps
// its own page stack and register copies, predicts the result word of every
// accepted request and checks returned words in order. Directed requests hit
// the pool edge cases, then randomized config phases run mixed alloc, free
// and init traffic under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tb_fpsa_pkg;
  import fpsa_pkg::*;

  localparam longint unsigned PageBytes  = 64'd1 << PageShift;
  localparam int unsigned     MaxReports = 10;

  class page_pool_scoreboard;
    logic [PageNumW-1:0] pages [MaxPages];
    int unsigned         depth;
    logic [AddrW-1:0]    kernel_end;
    logic [AddrW-1:0]    memory_top;
    out_word_t           pending_q [$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         status_seen [4];

    function new();
      kernel_end = KernelEndReset;
      memory_top = MemoryTopReset;
      depth      = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [AddrW-1:0] val);
      if (idx == CfgKernelEnd) begin
        kernel_end = val;
      end else begin
        memory_top = val;
      end
    endfunction

    function bit push_page(logic [PageNumW-1:0] pn);
      if (depth >= MaxPages) return 1'b0;
      pages[depth] = pn;
      depth++;
      return 1'b1;
    endfunction

    function out_word_t predict(in_word_t w);
      out_word_t       r;
      longint unsigned p;
      longint unsigned top;
      r.page_addr_out = '0;
      r.status        = StatOk;
      case (action_e'(w.action))
        ActAlloc: begin
          if (depth == 0) begin
            r.status = StatEmpty;
          end else begin
            depth--;
            r.page_addr_out = {pages[depth], {PageShift{1'b0}}};
          end
        end
        ActFree: begin
          if (w.page_addr_in[PageShift-1:0] != '0 || w.page_addr_in < kernel_end ||
              w.page_addr_in >= memory_top) begin
            r.status = StatBadAddr;
          end else if (!push_page(w.page_addr_in[AddrW-1:PageShift])) begin
            r.status = StatFull;
          end
        end
        ActInit: begin
          depth = 0;
          top   = {32'h0, memory_top};
          p     = ({32'h0, kernel_end} + PageBytes - 1) & ~(PageBytes - 1);
          while (p + PageBytes <= top) begin
            if (!push_page(p[AddrW-1:PageShift])) begin
              r.status = StatFull;
              break;
            end
            p += PageBytes;
          end
        end
        default: ;
      endcase
      r.free_count = FreeCntW'(depth);
      return r;
    endfunction

    function void note_request(in_word_t w);
      pending_q.push_back(predict(w));
    endfunction

    function void flag(string what, logic [AddrW-1:0] want, logic [AddrW-1:0] got);
      errors++;
      if (errors <= MaxReports) begin
        $display("mismatch on %s at word %0d: expected %h actual %h", what, checked, want, got);
      end
    endfunction

    function void check_word(out_word_t got);
      out_word_t want;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= MaxReports) $display("unexpected result word %h", got);
        return;
      end
      want = pending_q.pop_front();
      status_seen[want.status]++;
      if (got.page_addr_out !== want.page_addr_out)
        flag("page_addr_out", want.page_addr_out, got.page_addr_out);
      if (got.status !== want.status) flag("status", want.status, got.status);
      if (got.free_count !== want.free_count) flag("free_count", want.free_count, got.free_count);
    endfunction

    function int unsigned pending();
      return pending_q.size();
    endfunction
  endclass
endpackage

module tb_free_page_stack_allocator_top;
  import fpsa_pkg::*;
  import tb_fpsa_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned ItemTarget = 1100;
  localparam int unsigned LongHold   = 400;

  typedef enum int {RxFree, RxLight, RxHeavy, RxToggle, RxHold} rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_word_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i = '0;
  logic [AddrW-1:0]     cfg_wdata_i = '0;

  page_pool_scoreboard  sb = new();
  int unsigned          cycle_count = 0;
  int unsigned          hold_reqs   = 0;
  int unsigned          holds_done  = 0;
  int unsigned          burst_left  = 0;
  int unsigned          words_sent  = 0;
  int unsigned          n_alloc     = 0;
  int unsigned          n_free      = 0;
  int unsigned          n_init      = 0;
  int unsigned          n_phase     = 0;

  free_page_stack_allocator_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_request(in_word_i);
      if (out_valid_o && !out_stall_i) sb.check_word(out_word_o);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver stall pattern
  initial begin
    int unsigned seg;
    rx_mode_e    mode;
    forever begin
      seg  = $urandom_range(8, 64);
      mode = rx_mode_e'($urandom_range(0, 3));
      if (hold_reqs != holds_done) begin
        holds_done++;
        mode = RxHold;
        seg  = LongHold;
      end
      repeat (seg) begin
        @(posedge clk_i);
        case (mode)
          RxFree:   out_stall_i <= 1'b0;
          RxLight:  out_stall_i <= ($urandom_range(0, 3) == 0);
          RxHeavy:  out_stall_i <= ($urandom_range(0, 9) < 7);
          RxToggle: out_stall_i <= ~out_stall_i;
          default:  out_stall_i <= 1'b1;
        endcase
      end
    end
  end

  task automatic send_word(input action_e act, input logic [AddrW-1:0] addr);
    in_word_t    w;
    int unsigned gap;
    w.action       = act;
    w.page_addr_in = addr;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    words_sent++;
    case (act)
      ActAlloc: n_alloc++;
      ActFree:  n_free++;
      ActInit:  n_init++;
      default:  ;
    endcase
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap        = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic load_config(input logic [AddrW-1:0] ke, input logic [AddrW-1:0] mt,
                             input bit do_ke, input bit do_mt);
    drain_results();
    if (do_ke) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgKernelEnd;
      cfg_wdata_i <= ke;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(CfgKernelEnd, ke);
    end
    if (do_mt) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= CfgMemoryTop;
      cfg_wdata_i <= mt;
      do @(posedge clk_i); while (!cfg_ready_o);
      sb.write_reg(CfgMemoryTop, mt);
    end
    cfg_valid_i <= 1'b0;
    n_phase++;
  endtask

  task automatic pick_config(output logic [AddrW-1:0] ke, output logic [AddrW-1:0] mt);
    longint unsigned base;
    longint unsigned top;
    int unsigned     sel;
    sel = $urandom_range(0, 99);
    if (sel < 55) begin
      base = $urandom_range(0, 32'hFFF0_0000);
      if ($urandom_range(0, 1) == 0) base &= ~(PageBytes - 1);
      top = ((base + PageBytes - 1) & ~(PageBytes - 1)) + $urandom_range(0, 48) * PageBytes;
      if ($urandom_range(0, 1) == 0) top += $urandom_range(0, 4095);
    end else if (sel < 70) begin
      base = $urandom_range(0, 32'h8000_0000);
      top  = base + $urandom_range(32000, 34000) * PageBytes;
    end else if (sel < 80) begin
      top  = $urandom_range(0, 32'hFFFE_0000);
      base = top + $urandom_range(1, 65536);
    end else if (sel < 92) begin
      base = $urandom;
      top  = $urandom;
    end else begin
      case ($urandom_range(0, 3))
        0:       base = 64'h0;
        1:       base = 64'hFFFF_FFFF;
        2:       base = 64'hFFFF_F001;
        default: base = 64'hFFFF_F000;
      endcase
      top = ($urandom_range(0, 1) == 0) ? 64'h0 : 64'hFFFF_FFFF;
    end
    if (top > 64'hFFFF_FFFF) top = 64'hFFFF_FFFF;
    if (base > 64'hFFFF_FFFF) base = 64'hFFFF_FFFF;
    ke = base[AddrW-1:0];
    mt = top[AddrW-1:0];
  endtask

  function automatic logic [AddrW-1:0] pick_free_addr();
    longint unsigned lo;
    longint unsigned n;
    lo = ({32'h0, sb.kernel_end} + PageBytes - 1) & ~(PageBytes - 1);
    n  = (lo + PageBytes <= {32'h0, sb.memory_top}) ? (sb.memory_top - lo) >> PageShift : 0;
    if (n > 0 && $urandom_range(0, 99) < 65) begin
      if ($urandom_range(0, 1) == 0 && n > 8) n = 8;
      return AddrW'(lo + $urandom_range(0, n - 1) * PageBytes);
    end
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return (sb.kernel_end > 0) ?
                 ($urandom_range(0, sb.kernel_end - 1) & ~32'hFFF) : $urandom;
      2:       return sb.memory_top & ~32'hFFF;
      default: return AddrW'(lo) | $urandom_range(1, 4095);
    endcase
  endfunction

  task automatic random_word();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (sel < 3) send_word(ActNone, $urandom);
    else if (sel < 7) send_word(ActInit, $urandom);
    else if (sel < 52) send_word(ActAlloc, $urandom);
    else send_word(ActFree, pick_free_addr());
  endtask

  initial begin
    logic [AddrW-1:0] ke;
    logic [AddrW-1:0] mt;
    int unsigned      cnt;
    int unsigned      sel;

    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values, empty then full pool
    send_word(ActAlloc, 32'h0);
    send_word(ActNone, 32'hFFFF_FFFF);
    send_word(ActFree, 32'h8000_0000);
    send_word(ActAlloc, 32'h0);
    send_word(ActInit, 32'h0);
    send_word(ActAlloc, 32'h0);
    send_word(ActFree, 32'h87FF_F000);
    send_word(ActFree, 32'h87FF_F000);
    send_word(ActFree, 32'h8000_0800);
    send_word(ActFree, 32'h7FFF_F000);
    send_word(ActFree, 32'h8800_0000);
    send_word(ActAlloc, 32'h0);
    send_word(ActAlloc, 32'h0);

    // page zero usable, double free of it
    load_config(32'h0, 32'h0000_3000, 1'b1, 1'b1);
    send_word(ActInit, 32'h0);
    send_word(ActFree, 32'h0);
    repeat (5) send_word(ActAlloc, 32'h0);
    send_word(ActFree, 32'hFFFF_FFFF);

    // rounding of kernel end wraps past the address space
    load_config(32'hFFFF_F001, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(ActInit, 32'h0);
    send_word(ActFree, 32'hFFFF_F000);

    // inverted range
    load_config(32'h0001_0000, 32'h0000_8000, 1'b1, 1'b1);
    send_word(ActInit, 32'h0);

    // more pages than the pool holds
    load_config(32'h0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    send_word(ActInit, 32'h0);
    send_word(ActAlloc, 32'h0);
    send_word(ActFree, 32'hFFFF_E000);

    cnt = 0;
    while (cnt < ItemTarget) begin
      pick_config(ke, mt);
      sel = $urandom_range(0, 9);
      load_config(ke, mt, sel != 0 || n_phase < 6, sel != 1 || n_phase < 6);
      if (n_phase == 6 || n_phase == 12) hold_reqs++;
      if ($urandom_range(0, 99) < 85) begin
        send_word(ActInit, $urandom);
        cnt++;
      end
      repeat ($urandom_range(40, 110)) begin
        random_word();
        cnt++;
      end
    end

    drain_results();
    repeat (20) @(posedge clk_i);
    sb.errors += sb.pending();

    $display("covered %0d words in %0d register phases: %0d alloc, %0d free, %0d init",
             words_sent, n_phase, n_alloc, n_free, n_init);
    $display("results seen: %0d ok, %0d empty, %0d bad address, %0d full, %0d errors",
             sb.status_seen[StatOk], sb.status_seen[StatEmpty],
             sb.status_seen[StatBadAddr], sb.status_seen[StatFull], sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
